[hdl/hkrc_pkg.sv]
// ----------------------------------------------------------------------------
// hkrc_pkg
// Types, constants and helpers shared by the keyboard report composer.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrc_pkg;

   localparam int CODE_W       = 8;
   localparam int REPORT_SLOTS = 6;

   typedef enum logic [1:0] {
      OP_PRESS   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_ONESHOT = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PACK,
      ST_EMIT,
      ST_RELEASE
   } state_type;

   typedef enum logic [1:0] {
      KCMD_HOLD,
      KCMD_PRESS,
      KCMD_RELEASE,
      KCMD_SHIFT
   } key_cmd_type;

   typedef struct packed {
      key_cmd_type         cmd;
      logic                insert_en;
      logic [CODE_W-1:0]   code;
   } key_ctrl_type;

   typedef struct packed {
      logic                load;
      logic                shift;
      logic [CODE_W-1:0]   code;
   } os_ctrl_type;

   function automatic logic is_modifier(input logic [CODE_W-1:0] code);
      return code[7:3] == 5'b11100;
   endfunction

   function automatic logic [CODE_W-1:0] mod_mask(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] m;
      m = '0;
      if (is_modifier(code)) begin
         m[code[2:0]] = 1'b1;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[hdl/hkrc_key_cell.sv]
// ----------------------------------------------------------------------------
// hkrc_key_cell
// One key slot of the report: insert at first empty, clear on match, and
// pull from the right neighbor while packing.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrc_key_cell
   import hkrc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire key_ctrl_type       ctrl,
   input  wire logic               empty_before_in,
   input  wire logic [CODE_W-1:0]  right_slot,
   output logic [CODE_W-1:0]       slot,
   output logic                    empty_before_out,
   output logic                    match,
   output logic                    gap
);

   logic [CODE_W-1:0] slot_ff, slot_in;
   logic              empty;

   assign empty            = (slot_ff == '0);
   assign empty_before_out = empty_before_in | empty;
   assign match            = !empty && (slot_ff == ctrl.code);
   assign gap              = empty_before_in && !empty;
   assign slot             = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      case (ctrl.cmd)
         KCMD_PRESS: begin
            if (ctrl.insert_en && empty && !empty_before_in) begin
               slot_in = ctrl.code;
            end
         end
         KCMD_RELEASE: begin
            if (match) begin
               slot_in = '0;
            end
         end
         KCMD_SHIFT: begin
            if (empty_before_out) begin
               slot_in = right_slot;
            end
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire

[hdl/hkrc_os_cell.sv]
// ----------------------------------------------------------------------------
// hkrc_os_cell
// One entry of the one-shot log; loads when selected, shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrc_os_cell
   import hkrc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire os_ctrl_type        ctrl,
   input  wire logic               wr_sel,
   input  wire logic [CODE_W-1:0]  right_entry,
   output logic [CODE_W-1:0]       entry
);

   logic [CODE_W-1:0] entry_ff, entry_in;

   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = right_entry;
      end else if (ctrl.load && wr_sel) begin
         entry_in = ctrl.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

[hdl/hid_keyboard_report_composer.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_composer
// Boot keyboard report builder: modifier byte, a row of key slot cells and a
// row of one-shot log cells, driven by a small sequencer.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | opcode, key_code, host_ready
//   rsp     | out       | rsp_valid/rsp_stall | modifier_bits, slot_0..slot_5
//
// press, release and one-shot are applied in the execute step, and a tick without
// change returns to idle from there; a tick with change then packs the slots
// (one gap closed per cycle), loads the report if the host is ready and
// releases each logged one-shot code in turn
// reset clears all slots, the log, the modifier byte and the changed flag
// a stalled report holds the sequencer in its load step only
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_composer
   import hkrc_pkg::*;
#(
   parameter int KEY_SLOTS     = 6,
   parameter int ONESHOT_DEPTH = 14
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_opcode,
   input  wire logic [7:0]   req_key_code,
   input  wire logic         req_host_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_modifier_bits,
   output logic [7:0]        rsp_slot_0,
   output logic [7:0]        rsp_slot_1,
   output logic [7:0]        rsp_slot_2,
   output logic [7:0]        rsp_slot_3,
   output logic [7:0]        rsp_slot_4,
   output logic [7:0]        rsp_slot_5
);

   localparam int CNT_W = $clog2(ONESHOT_DEPTH + 1);

   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [CODE_W-1:0]  code_ff;
   logic               ready_ff;
   logic [CODE_W-1:0]  mod_ff, mod_in;
   logic               flag_ff, flag_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff;
   logic [CODE_W-1:0]  rsp_mod_ff;
   logic [CODE_W-1:0]  rsp_slot_ff [REPORT_SLOTS];

   key_ctrl_type       key_ctrl;
   os_ctrl_type        os_ctrl;
   logic               emit_load;

   logic [CODE_W-1:0]  slot_w  [KEY_SLOTS];
   logic [KEY_SLOTS:0] empty_chain;
   logic [KEY_SLOTS-1:0] match_w, gap_w;
   logic [CODE_W-1:0]  entry_w [ONESHOT_DEPTH];

   logic [CODE_W-1:0]  code_sel, m_sel;
   logic               is_mod, any_match, any_empty, any_gap;
   logic               press_chg, rel_chg, log_room;

   // key slot row
   assign empty_chain[0] = 1'b0;
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_key
      logic [CODE_W-1:0] right;
      if (i == KEY_SLOTS - 1) begin : g_last
         assign right = '0;
      end else begin : g_mid
         assign right = slot_w[i+1];
      end
      hkrc_key_cell u_cell (
         .clock            (clock),
         .reset            (reset),
         .ctrl             (key_ctrl),
         .empty_before_in  (empty_chain[i]),
         .right_slot       (right),
         .slot             (slot_w[i]),
         .empty_before_out (empty_chain[i+1]),
         .match            (match_w[i]),
         .gap              (gap_w[i])
      );
   end

   // one-shot log row
   for (genvar j = 0; j < ONESHOT_DEPTH; j++) begin : g_os
      logic [CODE_W-1:0] right;
      if (j == ONESHOT_DEPTH - 1) begin : g_last
         assign right = '0;
      end else begin : g_mid
         assign right = entry_w[j+1];
      end
      hkrc_os_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (os_ctrl),
         .wr_sel      (count_ff == CNT_W'(j)),
         .right_entry (right),
         .entry       (entry_w[j])
      );
   end

   assign code_sel  = (state_ff == ST_RELEASE) ? entry_w[0] : code_ff;
   assign is_mod    = is_modifier(code_sel);
   assign m_sel     = mod_mask(code_sel);
   assign any_match = |match_w;
   assign any_empty = empty_chain[KEY_SLOTS];
   assign any_gap   = |gap_w;
   assign log_room  = (count_ff < CNT_W'(ONESHOT_DEPTH));
   assign press_chg = is_mod ? ((mod_ff & m_sel) == '0)
                             : ((code_sel != '0) && !any_match && any_empty);
   assign rel_chg   = is_mod ? ((mod_ff & m_sel) != '0) : any_match;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_TICK && flag_ff) begin
               state_in = ST_PACK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PACK: begin
            if (!any_gap) begin
               state_in = ready_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = (count_ff != '0) ? ST_RELEASE : ST_IDLE;
            end
         end
         ST_RELEASE: begin
            if (count_ff <= CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      key_ctrl.cmd       = KCMD_HOLD;
      key_ctrl.insert_en = !is_mod && (code_sel != '0) && !any_match;
      key_ctrl.code      = code_sel;
      os_ctrl.load       = 1'b0;
      os_ctrl.shift      = 1'b0;
      os_ctrl.code       = code_ff;
      emit_load          = 1'b0;
      case (state_ff)
         ST_EXEC: begin
            case (op_ff)
               OP_PRESS: begin
                  key_ctrl.cmd = KCMD_PRESS;
               end
               OP_RELEASE: begin
                  key_ctrl.cmd = KCMD_RELEASE;
               end
               OP_ONESHOT: begin
                  if (log_room) begin
                     key_ctrl.cmd = KCMD_PRESS;
                     os_ctrl.load = press_chg;
                  end
               end
               default: begin
                  key_ctrl.cmd = KCMD_HOLD;
               end
            endcase
         end
         ST_PACK: begin
            if (any_gap) begin
               key_ctrl.cmd = KCMD_SHIFT;
            end
         end
         ST_EMIT: begin
            emit_load = !rsp_valid_ff || !rsp_stall;
         end
         ST_RELEASE: begin
            key_ctrl.cmd  = KCMD_RELEASE;
            os_ctrl.shift = 1'b1;
         end
         default: begin
            key_ctrl.cmd = KCMD_HOLD;
         end
      endcase
   end

   // modifier byte, changed flag, log count
   always_comb begin
      mod_in   = mod_ff;
      flag_in  = flag_ff;
      count_in = count_ff;
      case (state_ff)
         ST_EXEC: begin
            case (op_ff)
               OP_PRESS: begin
                  mod_in  = mod_ff | m_sel;
                  flag_in = flag_ff | press_chg;
               end
               OP_RELEASE: begin
                  mod_in  = mod_ff & ~m_sel;
                  flag_in = flag_ff | rel_chg;
               end
               OP_ONESHOT: begin
                  if (log_room) begin
                     mod_in = mod_ff | m_sel;
                     if (press_chg) begin
                        flag_in  = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
               end
               default: begin
                  mod_in = mod_ff;
               end
            endcase
         end
         ST_EMIT: begin
            if (emit_load) begin
               flag_in = 1'b0;
            end
         end
         ST_RELEASE: begin
            mod_in   = mod_ff & ~m_sel;
            flag_in  = flag_ff | rel_chg;
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
            mod_in = mod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= '0;
         flag_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
         flag_ff  <= flag_in;
         count_ff <= count_in;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff    <= op_type'(req_opcode);
         code_ff  <= req_key_code;
         ready_ff <= req_host_ready;
      end
      if (emit_load) begin
         rsp_mod_ff <= mod_ff;
      end
   end

   for (genvar k = 0; k < REPORT_SLOTS; k++) begin : g_rsp
      if (k < KEY_SLOTS) begin : g_slot
         always_ff @(posedge clock) begin
            if (emit_load) begin
               rsp_slot_ff[k] <= slot_w[k];
            end
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            if (emit_load) begin
               rsp_slot_ff[k] <= '0;
            end
         end
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_modifier_bits = rsp_mod_ff;
   assign rsp_slot_0        = rsp_slot_ff[0];
   assign rsp_slot_1        = rsp_slot_ff[1];
   assign rsp_slot_2        = rsp_slot_ff[2];
   assign rsp_slot_3        = rsp_slot_ff[3];
   assign rsp_slot_4        = rsp_slot_ff[4];
   assign rsp_slot_5        = rsp_slot_ff[5];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ONESHOT_DEPTH))
      else $error("one-shot count beyond depth");

   a_emit_clears_flag: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> !flag_ff)
      else $error("changed flag not cleared on report");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("report raised outside load step");
`endif

endmodule

`default_nettype wire
